FILE: design/fcsdc_pkg.sv
package fcsdc_pkg;

  // configuration register indexes
  localparam logic [3:0] REG_MODE    = 4'd0;
  localparam logic [3:0] REG_RATES12 = 4'd1;
  localparam logic [3:0] REG_RATE3   = 4'd2;
  localparam logic [3:0] REG_SHAPE   = 4'd3;
  localparam logic [3:0] REG_FRAC    = 4'd4;
  localparam logic [3:0] REG_DECAY   = 4'd5;
  localparam logic [3:0] REG_AMP     = 4'd6;
  localparam logic [3:0] REG_OFFSET  = 4'd7;

  localparam logic [32:0]        ONE_Q32 = 33'h1_0000_0000;
  localparam logic [62:0]        ONE_Q62 = 63'h4000_0000_0000_0000;
  localparam logic signed [51:0] ONE_Q48 = 52'sh1_0000_0000_0000;

  typedef struct packed {
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } pp_t;

  typedef struct packed {
    logic [64:0] a;
    logic [64:0] r;
    logic [32:0] q;
  } div1_t;

  typedef struct packed {
    logic [63:0] n;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [31:0] s;
    logic [31:0] r;
    logic [32:0] rest;
    logic [32:0] q;
  } div2_t;

  typedef struct packed {
    logic        zero;
    logic [57:0] r;
    logic [62:0] term;
    logic [62:0] sum;
    pp_t         pp;
    logic [63:0] v;
    logic [3:0]  rem;
    logic [63:0] qv;
  } tay_t;

  typedef struct packed {
    logic [15:0] q;
    logic [3:0]  rem;
  } cdiv_t;

  // four 32x32 partial products of a 64x64 multiply
  function automatic pp_t pp_split(input logic [63:0] a, input logic [63:0] b);
    pp_t p;
    p.ll = 64'(a[31:0]) * 64'(b[31:0]);
    p.lh = 64'(a[31:0]) * 64'(b[63:32]);
    p.hl = 64'(a[63:32]) * 64'(b[31:0]);
    p.hh = 64'(a[63:32]) * 64'(b[63:32]);
    return p;
  endfunction

  function automatic logic [127:0] pp_join(input pp_t p);
    return {64'd0, p.ll} + ({64'd0, p.lh} << 32) + ({64'd0, p.hl} << 32) + {p.hh, 64'd0};
  endfunction

  // 2^32 + x*shape/2^16, saturating at all ones
  function automatic logic [63:0] sat_shape(input pp_t p);
    logic [127:0] prod;
    logic [64:0]  bs;
    prod = pp_join(p);
    bs = {1'b0, prod[79:16]} + 65'(ONE_Q32);
    if (prod[87:80] != 8'd0 || bs[64]) begin
      return '1;
    end
    return bs[63:0];
  endfunction

  // one quotient bit of 2^64 / a
  function automatic div1_t div1_step(input div1_t d);
    logic [65:0] r2;
    div1_t o;
    o = d;
    r2 = {d.r, 1'b0};
    if (r2 >= {1'b0, d.a}) begin
      o.r = 65'(r2 - {1'b0, d.a});
      o.q = {d.q[31:0], 1'b1};
    end else begin
      o.r = r2[64:0];
      o.q = {d.q[31:0], 1'b0};
    end
    return o;
  endfunction

  // one root bit of the square root
  function automatic sq_t sq_step(input sq_t d);
    logic [33:0] rem2;
    logic [33:0] test;
    sq_t o;
    o = d;
    rem2 = {d.rem[31:0], d.n[63:62]};
    test = {d.root, 2'b01};
    o.n = {d.n[61:0], 2'b00};
    if (rem2 >= test) begin
      o.rem  = rem2 - test;
      o.root = {d.root[30:0], 1'b1};
    end else begin
      o.rem  = rem2;
      o.root = {d.root[30:0], 1'b0};
    end
    return o;
  endfunction

  // one quotient bit of (q << 16) / s
  function automatic div2_t div2_step(input div2_t d);
    logic [32:0] r2;
    div2_t o;
    o = d;
    r2 = {d.r, d.rest[32]};
    o.rest = {d.rest[31:0], 1'b0};
    if (r2 >= {1'b0, d.s}) begin
      o.r = 32'(r2 - {1'b0, d.s});
      o.q = {d.q[31:0], 1'b1};
    end else begin
      o.r = r2[31:0];
      o.q = {d.q[31:0], 1'b0};
    end
    return o;
  endfunction

  // 16-bit digit of a division by a small constant, reciprocal plus one correction
  function automatic cdiv_t chunk_div(input logic [3:0] rem_in, input logic [15:0] chunk,
                                      input logic [3:0] k, input logic [32:0] rcp);
    logic [19:0] cur;
    logic [52:0] prd;
    logic [15:0] qe;
    logic [19:0] rr;
    cdiv_t o;
    cur = {rem_in, chunk};
    prd = 53'(cur) * 53'(rcp);
    qe = prd[47:32];
    rr = cur - 20'(qe) * 20'(k);
    if (rr >= 20'(k)) begin
      o.q   = qe + 16'd1;
      o.rem = 4'(rr - 20'(k));
    end else begin
      o.q   = qe;
      o.rem = rr[3:0];
    end
    return o;
  endfunction

endpackage

FILE: design/fcs_diffusion_correlation_eval.sv
// an accepted lag moves through the stages in order and its result lands in the output register
// throughput: one lag per cycle while the output is not held; the datapath is a single 87-stage pipeline
// the longest path is the dark-term exponential (ten series steps, nine squarings)
// an output stall freezes every stage, so nothing is dropped or repeated
// reset: clears all stage valid bits and loads the register defaults
module fcs_diffusion_correlation_eval (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        lag_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] correlation_value,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import fcsdc_pkg::*;

  localparam int NST = 87;

  // configuration registers
  logic [3:0]         mode;
  logic [63:0]        diffusion_rates_12;
  logic [31:0]        diffusion_rate_3;
  logic [23:0]        inverse_shape_squared;
  logic [63:0]        fraction_words;
  logic [63:0]        decay_rates;
  logic [31:0]        amplitude_scale;
  logic signed [31:0] baseline_offset;

  assign cfg_ready = 1'b1;

  // a transaction on the config port writes one register, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      mode                  <= 4'd5;
      diffusion_rates_12    <= '0;
      diffusion_rate_3      <= '0;
      inverse_shape_squared <= 24'd1820;
      fraction_words        <= '0;
      decay_rates           <= '0;
      amplitude_scale       <= 32'd2097152;
      baseline_offset       <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:    mode                  <= cfg_data[3:0];
        REG_RATES12: diffusion_rates_12    <= cfg_data;
        REG_RATE3:   diffusion_rate_3      <= cfg_data[31:0];
        REG_SHAPE:   inverse_shape_squared <= cfg_data[23:0];
        REG_FRAC:    fraction_words        <= cfg_data;
        REG_DECAY:   decay_rates           <= cfg_data;
        REG_AMP:     amplitude_scale       <= cfg_data[31:0];
        REG_OFFSET:  baseline_offset       <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // pipeline control: every stage moves together unless the output is held
  logic [NST:1] vld;
  logic         adv;

  assign adv       = !vld[NST] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-1:1], in_valid};
    end
  end

  // stage 1: argument of every term, rate times lag
  logic [63:0] xs [3];
  logic [63:0] xd [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      xs[0] <= 64'(diffusion_rates_12[31:0]) * 64'(lag_time);
      xs[1] <= 64'(diffusion_rates_12[63:32]) * 64'(lag_time);
      xs[2] <= 64'(diffusion_rate_3) * 64'(lag_time);
      xd[0] <= 64'(decay_rates[31:0]) * 64'(lag_time);
      xd[1] <= 64'(decay_rates[63:32]) * 64'(lag_time);
    end
  end

  // species lanes: 1/(1+x) in stages 2..34, sqrt(1+x/gamma^2) in 2..35,
  // final quotient in 36..68
  div1_t       d1  [3][34];
  pp_t         shp [3];
  logic [63:0] bq  [3];
  sq_t         sq  [3][33];
  logic [32:0] qd  [3];
  div2_t       d2  [3][34];

  for (genvar l = 0; l < 3; l++) begin : g_sp
    always_comb begin
      d1[l][0].a = 65'(xs[l]) + 65'(ONE_Q32);
      d1[l][0].r = 65'h8000_0000;
      d1[l][0].q = '0;
    end

    for (genvar j = 1; j <= 33; j++) begin : g_d1
      always_ff @(posedge clk) begin
        if (adv) begin
          d1[l][j] <= div1_step(d1[l][j-1]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        shp[l] <= pp_split(xs[l], 64'(inverse_shape_squared));
        bq[l]  <= sat_shape(shp[l]);
        qd[l]  <= d1[l][33].q;
      end
    end

    always_comb begin
      sq[l][0].n    = bq[l];
      sq[l][0].rem  = '0;
      sq[l][0].root = '0;
    end

    for (genvar j = 1; j <= 32; j++) begin : g_sq
      always_ff @(posedge clk) begin
        if (adv) begin
          sq[l][j] <= sq_step(sq[l][j-1]);
        end
      end
    end

    // dividend is q << 16; its top bits start the remainder
    always_comb begin
      d2[l][0].s    = sq[l][32].root;
      d2[l][0].r    = {16'd0, qd[l][32:17]};
      d2[l][0].rest = {qd[l][16:0], 16'd0};
      d2[l][0].q    = '0;
    end

    for (genvar j = 1; j <= 33; j++) begin : g_d2
      always_ff @(posedge clk) begin
        if (adv) begin
          d2[l][j] <= div2_step(d2[l][j-1]);
        end
      end
    end
  end

  // dark lanes: exp(-x) as a ten-step series on x/512 (stages 2..61),
  // then nine squarings (stages 62..79)
  tay_t ex [2][79];

  for (genvar l = 0; l < 2; l++) begin : g_ex
    always_comb begin
      ex[l][0].zero = (xd[l][63:37] != 27'd0);
      ex[l][0].r    = {xd[l][36:0], 21'd0};
      ex[l][0].term = ONE_Q62;
      ex[l][0].sum  = ONE_Q62;
      ex[l][0].pp   = '0;
      ex[l][0].v    = '0;
      ex[l][0].rem  = '0;
      ex[l][0].qv   = '0;
    end

    for (genvar j = 1; j <= 78; j++) begin : g_st
      if (j <= 60) begin : g_tay
        localparam int K   = (j - 1) / 6 + 1;
        localparam int SUB = (j - 1) % 6;
        if (SUB == 0) begin : g_pp
          tay_t nx;
          always_comb begin
            nx    = ex[l][j-1];
            nx.pp = pp_split(64'(ex[l][j-1].term), 64'(ex[l][j-1].r));
          end
          always_ff @(posedge clk) begin
            if (adv) begin
              ex[l][j] <= nx;
            end
          end
        end else if (SUB == 1) begin : g_join
          logic [127:0] pj;
          tay_t         nx;
          assign pj = pp_join(ex[l][j-1].pp);
          always_comb begin
            nx     = ex[l][j-1];
            nx.v   = {1'b0, pj[124:62]};
            nx.rem = '0;
            nx.qv  = '0;
          end
          always_ff @(posedge clk) begin
            if (adv) begin
              ex[l][j] <= nx;
            end
          end
        end else begin : g_div
          // divide by k one 16-bit digit per stage, top digit first
          localparam int          C    = 5 - SUB;
          localparam bit          LAST = (SUB == 5);
          localparam bit          ODD  = (K % 2) == 1;
          localparam logic [32:0] RCP  = 33'((64'd1 << 32) / K);
          cdiv_t cd;
          tay_t  nx;
          assign cd = chunk_div(ex[l][j-1].rem, ex[l][j-1].v[16*C +: 16], 4'(K), RCP);
          always_comb begin
            nx = ex[l][j-1];
            nx.qv[16*C +: 16] = cd.q;
            nx.rem = cd.rem;
            if (LAST) begin
              nx.term = nx.qv[62:0];
              nx.sum  = ODD ? ex[l][j-1].sum - nx.term : ex[l][j-1].sum + nx.term;
            end
          end
          always_ff @(posedge clk) begin
            if (adv) begin
              ex[l][j] <= nx;
            end
          end
        end
      end else begin : g_sqr
        localparam int SUB = (j - 61) % 2;
        if (SUB == 0) begin : g_pp
          tay_t nx;
          always_comb begin
            nx    = ex[l][j-1];
            nx.pp = pp_split(64'(ex[l][j-1].sum), 64'(ex[l][j-1].sum));
          end
          always_ff @(posedge clk) begin
            if (adv) begin
              ex[l][j] <= nx;
            end
          end
        end else begin : g_join
          logic [127:0] pj;
          tay_t         nx;
          assign pj = pp_join(ex[l][j-1].pp);
          always_comb begin
            nx     = ex[l][j-1];
            nx.sum = pj[124:62];
          end
          always_ff @(posedge clk) begin
            if (adv) begin
              ex[l][j] <= nx;
            end
          end
        end
      end
    end
  end

  // species weights: rho1 takes what rho2 and rho3 leave
  logic [1:0]         n_sp;
  logic signed [17:0] w [3];

  assign n_sp = (mode[1:0] == 2'd0) ? 2'd1 : mode[1:0];

  always_comb begin
    w[1] = (n_sp >= 2'd2) ? signed'({2'b00, fraction_words[15:0]}) : 18'sd0;
    w[2] = (n_sp == 2'd3) ? signed'({2'b00, fraction_words[31:16]}) : 18'sd0;
    w[0] = 18'sd65536 - w[1] - w[2];
  end

  // stage 69 weighted terms, stage 70 species sum, delayed to stage 81
  logic signed [51:0] sprod [3];
  logic signed [51:0] sdl [12];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sprod[i] <= 52'(w[i]) * 52'(signed'({1'b0, d2[i][33].q}));
      end
      sdl[0] <= sprod[0] + sprod[1] + sprod[2];
      for (int i = 1; i < 12; i++) begin
        sdl[i] <= sdl[i-1];
      end
    end
  end

  // stage 80 theta*(1-e), stage 81 dark factor
  logic [32:0]        ev [2];
  logic [48:0]        pc [2];
  logic signed [51:0] pval;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      ev[i] = ex[i][78].zero ? 33'd0 : ex[i][78].sum[62:30];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pc[0] <= 49'(fraction_words[47:32]) * 49'(ONE_Q32 - ev[0]);
      pc[1] <= 49'(fraction_words[63:48]) * 49'(ONE_Q32 - ev[1]);
      pval  <= ONE_Q48 - ((mode[3:2] != 2'd0) ? signed'(52'(pc[0])) : 52'sd0)
                       - (mode[3] ? signed'(52'(pc[1])) : 52'sd0);
    end
  end

  // stages 82..86: magnitudes, |P|*|S|/2^64, then times amplitude/2^32
  logic [4:0]   ngd;
  logic [50:0]  mp;
  logic [50:0]  ms;
  pp_t          pp1;
  pp_t          pp2;
  logic [37:0]  mag;
  logic [37:0]  mag2;
  logic [127:0] j1;
  logic [127:0] j2;

  assign j1 = pp_join(pp1);
  assign j2 = pp_join(pp2);

  always_ff @(posedge clk) begin
    if (adv) begin
      ngd  <= {ngd[3:0], pval[51] ^ sdl[11][51]};
      mp   <= pval[51] ? 51'(-pval) : pval[50:0];
      ms   <= sdl[11][51] ? 51'(-sdl[11]) : sdl[11][50:0];
      pp1  <= pp_split(64'(mp), 64'(ms));
      mag  <= j1[101:64];
      pp2  <= pp_split(64'(mag), 64'(amplitude_scale));
      mag2 <= j2[69:32];
    end
  end

  // stage 87: sign, offset and clipping into the output register
  logic signed [39:0] mv;
  logic signed [39:0] gs;

  always_comb begin
    mv = ngd[4] ? -signed'({2'b00, mag2}) : signed'({2'b00, mag2});
    gs = mv + 40'(baseline_offset);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (gs > 40'sd2147483647) begin
        correlation_value <= 32'sh7FFF_FFFF;
        saturated         <= 1'b1;
      end else if (gs < -40'sd2147483648) begin
        correlation_value <= 32'sh8000_0000;
        saturated         <= 1'b1;
      end else begin
        correlation_value <= gs[31:0];
        saturated         <= 1'b0;
      end
    end
  end

  // a clipped result sits at one of the range ends
  a_sat_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (correlation_value == 32'sh7FFF_FFFF || correlation_value == 32'sh8000_0000))
    else $error("saturated result not at a range limit");

  // a held pipe keeps every item in place
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("valid bits moved during a stall");

  // square root of 1+x/gamma^2 is never below one
  a_root_min: assert property (@(posedge clk) disable iff (rst)
    vld[35] |-> (sq[0][32].root[31:16] != 16'd0 && sq[1][32].root[31:16] != 16'd0 &&
                 sq[2][32].root[31:16] != 16'd0))
    else $error("square root below one");

  // exponential stays within one
  a_exp_max: assert property (@(posedge clk) disable iff (rst)
    vld[79] |-> (ex[0][78].sum <= ONE_Q62 && ex[1][78].sum <= ONE_Q62))
    else $error("exponential above one");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

FILE: tb/fcs_diffusion_correlation_eval_tb.sv
module fcs_diffusion_correlation_eval_tb;
  import fcsdc_pkg::*;

  // cycles without any transaction before the run is declared hung
  localparam int STALL_LIMIT = 20000;
  // pipeline depth plus margin, waited out after the last result
  localparam int SETTLE = 100;
  // an index past the last register, the write must be ignored
  localparam logic [3:0] REG_NONE = 4'd12;

  typedef struct packed {
    logic signed [31:0] value;
    logic               sat;
  } corr_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        lag_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] correlation_value;
  logic               saturated;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [3:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;

  // shadow copy of the register file
  logic [3:0]  m_mode;
  logic [63:0] m_rates12;
  logic [31:0] m_rate3;
  logic [23:0] m_shape;
  logic [63:0] m_frac;
  logic [63:0] m_decay;
  logic [31:0] m_amp;
  logic [31:0] m_offset;

  corr_t pending_corr[$];
  int    mismatches = 0;
  int    send_idle_pct = 31;
  int    recv_stall_pct = 83;
  int    quiet_cycles = 0;

  fcs_diffusion_correlation_eval u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .lag_time(lag_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .correlation_value(correlation_value), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- fixed-point predictor ----------------

  // floor(a*b / 2^sh), saturating to 64 bits
  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    if (p[127:64] != '0) return '1;
    return p[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 1/(1+x) / sqrt(1 + x/gamma^2) in Q0.32, x in Q32.32
  function automatic logic [63:0] diffusion_term(logic [63:0] x);
    logic [127:0] num;
    logic [63:0]  q;
    logic [63:0]  y;
    logic [63:0]  b;
    num = 128'd1 << 64;
    q = 64'(num / {64'd0, x + 64'h1_0000_0000});
    y = mul_shr(x, {40'd0, m_shape}, 16);
    b = (y > 64'hFFFF_FFFE_FFFF_FFFF) ? '1 : y + 64'h1_0000_0000;
    return (q << 16) / int_sqrt(b);
  endfunction

  // exp(-x) in Q0.32: series on x/512, then nine squarings
  function automatic logic [63:0] decay_exp(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] acc;
    if ((x >> 37) != 0) return '0;
    r = x << 21;
    term = 64'h4000_0000_0000_0000;
    acc = term;
    for (int k = 1; k <= 10; k++) begin
      term = mul_shr(term, r, 62) / k;
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    for (int k = 0; k < 9; k++) acc = mul_shr(acc, acc, 62);
    return acc >> 30;
  endfunction

  function automatic logic [63:0] lag_product(logic [31:0] rate, logic [31:0] t);
    return {32'd0, rate} * {32'd0, t};
  endfunction

  function automatic corr_t model_correlation(logic [31:0] t);
    int unsigned species;
    int unsigned dark;
    longint      rho1, rho2, rho3, mix, triplet, g;
    logic [63:0] mag_s, mag_p, mag;
    logic        neg;
    corr_t       res;
    species = m_mode[1:0];
    dark = m_mode[3:2];
    if (species == 0) species = 1;
    if (dark == 3) dark = 2;
    rho1 = 65536;
    rho2 = longint'({48'd0, m_frac[15:0]});
    rho3 = longint'({48'd0, m_frac[31:16]});
    mix = 0;
    if (species >= 2) begin
      mix += rho2 * longint'(diffusion_term(lag_product(m_rates12[63:32], t)));
      rho1 -= rho2;
    end
    if (species >= 3) begin
      mix += rho3 * longint'(diffusion_term(lag_product(m_rate3, t)));
      rho1 -= rho3;
    end
    mix += rho1 * longint'(diffusion_term(lag_product(m_rates12[31:0], t)));
    triplet = longint'(64'd1 << 48);
    if (dark >= 1)
      triplet -= longint'({48'd0, m_frac[47:32]} *
                 (64'h1_0000_0000 - decay_exp(lag_product(m_decay[31:0], t))));
    if (dark >= 2)
      triplet -= longint'({48'd0, m_frac[63:48]} *
                 (64'h1_0000_0000 - decay_exp(lag_product(m_decay[63:32], t))));
    neg = (mix < 0) != (triplet < 0);
    mag_s = (mix < 0) ? 64'(-mix) : 64'(mix);
    mag_p = (triplet < 0) ? 64'(-triplet) : 64'(triplet);
    mag = mul_shr(mag_p, mag_s, 64);
    mag = mul_shr(mag, {32'd0, m_amp}, 32);
    g = (neg ? -longint'(mag) : longint'(mag)) + longint'(signed'(m_offset));
    res.sat = 1'b0;
    if (g > 64'sd2147483647) begin
      g = 64'sd2147483647;
      res.sat = 1'b1;
    end else if (g < -64'sd2147483648) begin
      g = -64'sd2147483648;
      res.sat = 1'b1;
    end
    res.value = g[31:0];
    return res;
  endfunction

  task automatic load_defaults();
    m_mode = 4'd5;
    m_rates12 = '0;
    m_rate3 = '0;
    m_shape = 24'd1820;
    m_frac = '0;
    m_decay = '0;
    m_amp = 32'd2097152;
    m_offset = '0;
  endtask

  // ---------------- drivers ----------------

  task automatic write_reg(logic [3:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:    m_mode = data[3:0];
      REG_RATES12: m_rates12 = data;
      REG_RATE3:   m_rate3 = data[31:0];
      REG_SHAPE:   m_shape = data[23:0];
      REG_FRAC:    m_frac = data;
      REG_DECAY:   m_decay = data;
      REG_AMP:     m_amp = data[31:0];
      REG_OFFSET:  m_offset = data[31:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays high after acceptance so back-to-back lags need no extra step
  task automatic send_lag(logic [31:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    lag_time <= t;
    do @(posedge clk); while (!in_ready);
    pending_corr.push_back(model_correlation(t));
  endtask

  // lower valid and wait until every result is back and the pipe is empty
  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_corr.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_all(logic [3:0] md, logic [63:0] r12, logic [63:0] r3,
                           logic [63:0] shp, logic [63:0] fr, logic [63:0] dec,
                           logic [63:0] amp, logic [63:0] off);
    write_reg(REG_MODE, md);
    write_reg(REG_RATES12, r12);
    write_reg(REG_RATE3, r3);
    write_reg(REG_SHAPE, shp);
    write_reg(REG_FRAC, fr);
    write_reg(REG_DECAY, dec);
    write_reg(REG_AMP, amp);
    write_reg(REG_OFFSET, off);
  endtask

  function automatic logic [31:0] rand_scaled();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  function automatic logic [31:0] rand_lag();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 255);
      2: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
      default: return rand_scaled();
    endcase
  endfunction

  // ---------------- tests ----------------

  // reset register values, lag extremes
  task automatic test_reset_defaults();
    send_lag(32'd0);
    send_lag(32'd1);
    send_lag(32'hFFFF_FFFF);
    drain_pipe();
  endtask

  // one, two, three species and the zero count that acts as one
  task automatic test_species_counts();
    write_all(4'b0001, {32'h0100_0000, 32'h0001_0000}, 64'h0000_0010_0000_0000,
              64'h0000_1000, {32'd0, 16'h4000, 16'h3000}, 64'd0, 64'h0100_0000, 64'd0);
    send_lag(32'd100);
    drain_pipe();
    write_reg(REG_MODE, 64'h2);
    send_lag(32'd100);
    drain_pipe();
    write_reg(REG_MODE, 64'h3);
    send_lag(32'd100);
    send_lag(32'hFFFF_FFFF);
    drain_pipe();
    write_reg(REG_MODE, 64'h0);
    send_lag(32'd100);
    drain_pipe();
  endtask

  // one and two dark terms, the count of three, thetas of one half and three quarters
  task automatic test_dark_terms();
    write_all(4'b0101, {32'd0, 32'h0010_0000}, 64'd0, 64'h1_0000,
              {16'hC000, 16'h8000, 32'd0}, {32'h0200_0000, 32'h4000_0000},
              64'h0100_0000, 64'd0);
    send_lag(32'd0);
    send_lag(32'd3);
    drain_pipe();
    write_reg(REG_MODE, 64'h9);
    send_lag(32'd3);
    send_lag(32'd200);
    drain_pipe();
    write_reg(REG_MODE, 64'hF);
    send_lag(32'd7);
    drain_pipe();
  endtask

  // zero shape, fractions above one, upward saturation, the lowest offset, ignored index
  task automatic test_corner_cases();
    write_all(4'b1011, '1, '1, 64'd0, '1, '1, 64'h0100_0000, 64'd0);
    send_lag(32'd1);
    send_lag(32'h0000_FFFF);
    drain_pipe();
    write_reg(REG_AMP, '1);
    write_reg(REG_OFFSET, 64'h7FFF_FFFF);
    write_reg(REG_FRAC, 64'd0);
    write_reg(REG_MODE, 64'h1);
    send_lag(32'd0);
    drain_pipe();
    write_reg(REG_FRAC, 64'h0000_0000_0000_FFFF);
    write_reg(REG_MODE, 64'h2);
    write_reg(REG_OFFSET, 64'h8000_0000);
    send_lag(32'd0);
    drain_pipe();
    write_reg(REG_NONE, 64'h0);
    write_reg(REG_SHAPE, '1);
    send_lag(32'd1000);
    send_lag(32'hFFFF_FFFF);
    drain_pipe();
  endtask

  // random register sets, each followed by a burst of random lags
  task automatic test_random_lags();
    for (int phase = 0; phase < 17; phase++) begin
      if (phase == 6) begin
        send_idle_pct = 83;
        recv_stall_pct = 31;
      end else if (phase == 12) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_all(4'($urandom), {rand_scaled(), rand_scaled()}, {$urandom, rand_scaled()},
                ($urandom_range(0, 5) == 0) ? 64'd0 : {$urandom, $urandom},
                ($urandom_range(0, 2) == 0) ? {$urandom, $urandom} :
                  {16'($urandom_range(0, 16384)), 16'($urandom_range(0, 16384)),
                   16'($urandom_range(0, 30000)), 16'($urandom_range(0, 30000))},
                {rand_scaled(), rand_scaled()}, {$urandom, rand_scaled()},
                {$urandom, ($urandom_range(0, 1) != 0) ? $urandom : rand_scaled()});
      for (int n = 0; n < 100; n++) send_lag(rand_lag());
      drain_pipe();
    end
  endtask

  // ---------------- result checking ----------------

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (pending_corr.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result value=%0d sat=%0b", correlation_value, saturated);
        end else begin
          corr_t want;
          want = pending_corr.pop_front();
          if (correlation_value !== want.value || saturated !== want.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value=%0d sat=%0b, got value=%0d sat=%0b",
                       want.value, want.sat, correlation_value, saturated);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    load_defaults();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_species_counts();
    test_dark_terms();
    test_corner_cases();
    test_random_lags();
    if (pending_corr.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: fcs_diffusion_correlation_eval.f
design/fcsdc_pkg.sv
design/fcs_diffusion_correlation_eval.sv
tb/fcs_diffusion_correlation_eval_tb.sv
